### src/mbr_pkg.sv
`default_nettype none
package mbr_pkg;

  localparam int POS_W = 5;
  localparam int MAX_PACKETS = 16;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic       we;
    pos_t       addr;
    logic [7:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic re;
    pos_t addr;
  } buf_rd_t;

endpackage
`default_nettype wire

### src/mbr_ifs.sv
`default_nettype none
interface mbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

interface mbr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mailbox_index;
  logic [3:0] byte_index;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, mailbox_index, byte_index, data_byte, last, input ready);
  modport sink (input valid, mailbox_index, byte_index, data_byte, last, output ready);
endinterface

interface mbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [39:0] size_word;
  modport source (output valid, size_word, input ready);
  modport sink (input valid, size_word, output ready);
endinterface
`default_nettype wire

### src/mbr_buf.sv
`default_nettype none
module mbr_buf #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  mbr_pkg::buf_wr_t wr,
  input  mbr_pkg::buf_rd_t rd,
  output logic [7:0]      rd_data
);
  import mbr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       q_r;
  logic             qv_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.re) begin
      q_r <= mem[rd.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr.we) begin
        vld_r[wr.addr[AW-1:0]] <= 1'b1;
      end
      if (rd.re) begin
        qv_r <= vld_r[rd.addr[AW-1:0]];
      end
    end
  end

  // entries not written since the last clr or reset read as zero
  assign rd_data = qv_r ? q_r : 8'h00;

endmodule
`default_nettype wire

### src/seven_bit_framed_mailbox_receiver.sv
`default_nettype none
// seven-bit framed mailbox receiver
// in_if carries one received serial byte per request (rx_byte); cfg_if writes
// the 40-bit mailbox size register (eight 5-bit byte counts, saturated to
// MAX_BYTES); out_if delivers decoded bytes with mailbox_index, byte_index,
// data_byte and last
// a header or checksum byte is taken while idle; for a data packet the
// sequencer reads, merges and writes back the two buffer bytes it spans
// through the registered buffer read port (states S_PK0, S_PK1, S_PK2)
// a matching checksum starts a burst of up to MAX_BYTES results: each
// result is read from the buffer memory, then loaded into the output
// register before the next read begins (memory read, then output register)
// in_if.ready is low while a packet or a burst is in progress; the output
// register lets a new request be taken while the last result still waits
// a stalled out_if holds the burst in place, nothing is dropped
// reset clears the phase, the size register and the buffer valid bits;
// no clearing pass is needed, the block is ready as soon as reset is released
module seven_bit_framed_mailbox_receiver #(
  parameter int MAX_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  mbr_cfg_if.sink          cfg_if,
  mbr_in_if.sink           in_if,
  mbr_out_if.source        out_if
);
  import mbr_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_CHECK  = 2'd2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PK0  = 3'd1;
  localparam logic [2:0] S_PK1  = 3'd2;
  localparam logic [2:0] S_PK2  = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_DOUT = 3'd5;

  localparam pos_t MAX_POS = pos_t'(MAX_BYTES);

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  dest_r, dest_nxt;
  logic [4:0]  exp_r, exp_nxt;
  logic [4:0]  seen_r, seen_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [6:0]  pkt_r, pkt_nxt;
  logic [6:0]  start_r, start_nxt;
  logic [4:0]  size_r, size_nxt;
  pos_t        k_r, k_nxt;
  logic [39:0] sizes_r;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_mb_r;
  logic [3:0]  out_idx_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        out_load;

  logic        in_acc;
  logic [7:0]  b;
  logic [4:0]  hdr_len, hdr_pkts;
  logic [4:0]  size_fld, size_sat;
  logic [4:0]  seen_inc;
  logic [7:0]  seen_x7, exp_x7;
  logic [4:0]  have;
  logic [3:0]  shamt;
  logic [15:0] win;
  pos_t        pos0, pos1;
  logic        out_free;
  logic        k_last;

  buf_wr_t     buf_wr;
  buf_rd_t     buf_rd;
  logic        buf_clr;
  logic [7:0]  buf_q;

  mbr_buf #(.DEPTH(MAX_BYTES)) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (buf_clr),
    .wr      (buf_wr),
    .rd      (buf_rd),
    .rd_data (buf_q)
  );

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (state_r == S_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign b            = in_if.rx_byte;

  // ceil(8L/7) for L of 1..16
  assign hdr_len  = {1'b0, b[3:0]} + 5'd1;
  assign hdr_pkts = hdr_len + ((hdr_len <= 5'd7) ? 5'd1 : ((hdr_len <= 5'd14) ? 5'd2 : 5'd3));

  assign size_fld = sizes_r[5*dest_r +: 5];
  assign size_sat = (size_fld > MAX_POS) ? MAX_POS : size_fld;
  assign seen_inc = seen_r + 5'd1;
  assign seen_x7  = {seen_r, 3'b000} - {3'b000, seen_r};
  assign exp_x7   = {exp_r, 3'b000} - {3'b000, exp_r};
  assign have     = exp_x7[7:3];

  // packet bits placed msb first into the two bytes at the stream position
  assign shamt = 4'd9 - {1'b0, start_r[2:0]};
  assign win   = {9'b0, pkt_r} << shamt;
  assign pos0  = {1'b0, start_r[6:3]};
  assign pos1  = pos0 + 5'd1;

  assign out_free = !out_valid_r || out_if.ready;
  assign k_last   = ((k_r + 5'd1) == size_r);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    dest_nxt  = dest_r;
    exp_nxt   = exp_r;
    seen_nxt  = seen_r;
    xor_nxt   = xor_r;
    pkt_nxt   = pkt_r;
    start_nxt = start_r;
    size_nxt  = size_r;
    k_nxt     = k_r;
    buf_clr   = 1'b0;
    buf_wr    = '{we: 1'b0, addr: pos0, data: buf_q | win[15:8]};
    buf_rd    = '{re: 1'b0, addr: pos0};
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            PH_DATA: begin
              if (b[7]) begin
                phase_nxt = PH_HEADER;
              end else begin
                pkt_nxt   = b[6:0];
                start_nxt = seen_x7[6:0];
                xor_nxt   = xor_r ^ b;
                seen_nxt  = seen_inc;
                if (seen_inc >= exp_r) begin
                  phase_nxt = PH_CHECK;
                end
                state_nxt = S_PK0;
              end
            end
            PH_CHECK: begin
              phase_nxt = PH_HEADER;
              size_nxt  = size_sat;
              k_nxt     = '0;
              if (!b[7] && b == xor_r && size_sat != 5'd0) begin
                state_nxt = S_DRD;
              end
            end
            default: begin
              phase_nxt = PH_HEADER;
              if (b[7] && hdr_pkts <= 5'(MAX_PACKETS)) begin
                dest_nxt  = b[6:4];
                exp_nxt   = hdr_pkts;
                seen_nxt  = '0;
                xor_nxt   = '0;
                buf_clr   = 1'b1;
                phase_nxt = PH_DATA;
              end
            end
          endcase
        end
      end
      S_PK0: begin
        buf_rd    = '{re: (pos0 < MAX_POS), addr: pos0};
        state_nxt = S_PK1;
      end
      S_PK1: begin
        buf_wr    = '{we: (pos0 < MAX_POS), addr: pos0, data: buf_q | win[15:8]};
        buf_rd    = '{re: (pos1 < MAX_POS), addr: pos1};
        state_nxt = S_PK2;
      end
      S_PK2: begin
        buf_wr    = '{we: (pos1 < MAX_POS), addr: pos1, data: buf_q | win[7:0]};
        state_nxt = S_IDLE;
      end
      S_DRD: begin
        buf_rd    = '{re: 1'b1, addr: k_r};
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (k_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 5'd1;
            state_nxt = S_DRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HEADER;
      dest_r      <= '0;
      exp_r       <= '0;
      seen_r      <= '0;
      xor_r       <= '0;
      size_r      <= '0;
      k_r         <= '0;
      sizes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      dest_r      <= dest_nxt;
      exp_r       <= exp_nxt;
      seen_r      <= seen_nxt;
      xor_r       <= xor_nxt;
      size_r      <= size_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        sizes_r <= cfg_if.size_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    pkt_r   <= pkt_nxt;
    start_r <= start_nxt;
    if (out_load) begin
      out_mb_r   <= dest_r;
      out_idx_r  <= k_r[3:0];
      out_data_r <= (k_r < have) ? buf_q : 8'h00;
      out_last_r <= k_last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.mailbox_index = out_mb_r;
  assign out_if.byte_index    = out_idx_r;
  assign out_if.data_byte     = out_data_r;
  assign out_if.last          = out_last_r;

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_wr.we |-> buf_wr.addr < MAX_POS)
    else $error("buffer write beyond MAX_BYTES");

  a_data_open: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> seen_r < exp_r)
    else $error("data phase with all packets seen");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (k_r >= have) |=> out_if.data_byte == 8'h00)
    else $error("byte beyond received length not zero");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_if.last == ((5'(out_if.byte_index) + 5'd1) == size_r))
    else $error("last flag out of place");

endmodule
`default_nettype wire

### test/tb_seven_bit_framed_mailbox_receiver.sv
`default_nettype none
module tb_seven_bit_framed_mailbox_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES = 16;
  localparam int MAX_PACKETS = mbr_pkg::MAX_PACKETS;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int DRAIN_PAUSE = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] HDR_BIT = 8'h80;
  localparam logic [7:0] MB_MASK = 8'h70;
  localparam logic [7:0] LEN_MASK = 8'h0F;
  localparam logic [7:0] PKT_MASK = 8'h7F;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_DATA,
    PH_CHECK
  } rx_phase_e;

  typedef enum int {
    FR_GOOD,
    FR_ABORT,
    FR_CK_HIGH,
    FR_CK_WRONG
  } frame_fault_e;

  typedef struct packed {
    logic [2:0] mailbox;
    logic [3:0] pos;
    logic [7:0] data;
    logic       last;
  } mb_byte_t;

  logic clk;
  logic rst_n;

  mbr_cfg_if cfg_if ();
  mbr_in_if  in_if ();
  mbr_out_if out_if ();

  seven_bit_framed_mailbox_receiver #(
    .MAX_BYTES(MAX_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_if(cfg_if),
    .in_if (in_if),
    .out_if(out_if)
  );

  // predictor state
  logic [39:0] sizes_reg;
  rx_phase_e   rx_phase;
  logic [2:0]  rx_mailbox;
  logic [4:0]  pkts_needed;
  logic [4:0]  pkts_seen;
  logic [7:0]  rx_xor;
  logic [7:0]  msg_buf[MAX_BYTES];

  logic [7:0] rx_pending[$];
  mb_byte_t   expected_bytes[$];

  int  idle_pct;
  int  stall_pct;
  bit  in_taken;
  int  errors;
  int  cycles;
  int  n_requests;
  int  n_bursts;
  int  n_checked;
  int  n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic deliver_msg();
    int sz;
    int have;
    mb_byte_t r;
    sz = int'(sizes_reg[5*rx_mailbox +: 5]);
    if (sz > MAX_BYTES) sz = MAX_BYTES;
    have = (pkts_needed * 7) / 8;
    if (sz > 0) n_bursts++;
    for (int k = 0; k < sz; k++) begin
      r.mailbox = rx_mailbox;
      r.pos = k[3:0];
      r.data = (k < have) ? msg_buf[k] : 8'h00;
      r.last = (k + 1 == sz);
      expected_bytes.push_back(r);
    end
  endtask

  task automatic decode_rx(input logic [7:0] b);
    int pos;
    int pkts;
    case (rx_phase)
      PH_DATA: begin
        if ((b & HDR_BIT) != 0) begin
          rx_phase = PH_WAIT;
        end else begin
          for (int i = 0; i < 7; i++) begin
            pos = pkts_seen * 7 + i;
            if (pos / 8 < MAX_BYTES && b[6-i]) msg_buf[pos/8][7 - pos%8] = 1'b1;
          end
          rx_xor = rx_xor ^ b;
          pkts_seen = pkts_seen + 5'd1;
          if (pkts_seen >= pkts_needed) rx_phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if ((b & HDR_BIT) == 0 && b == rx_xor) deliver_msg();
        rx_phase = PH_WAIT;
      end
      default: begin
        if ((b & HDR_BIT) != 0) begin
          pkts = ((int'(b & LEN_MASK) + 1) * 8 + 6) / 7;
          if (pkts <= MAX_PACKETS) begin
            rx_mailbox = 3'((b & MB_MASK) >> 4);
            pkts_needed = pkts[4:0];
            pkts_seen = '0;
            rx_xor = '0;
            for (int i = 0; i < MAX_BYTES; i++) msg_buf[i] = '0;
            rx_phase = PH_DATA;
          end
        end else begin
          rx_phase = PH_WAIT;
        end
      end
    endcase
  endtask

  task automatic check_result();
    mb_byte_t got;
    mb_byte_t want;
    got.mailbox = out_if.mailbox_index;
    got.pos = out_if.byte_index;
    got.data = out_if.data_byte;
    got.last = out_if.last;
    if (expected_bytes.size() == 0) begin
      note_error($sformatf("unexpected result mb=%0d idx=%0d data=%02h last=%0b",
                           got.mailbox, got.pos, got.data, got.last));
    end else begin
      want = expected_bytes.pop_front();
      n_checked++;
      if (got.mailbox !== want.mailbox || got.pos !== want.pos ||
          got.data !== want.data || got.last !== want.last)
        note_error($sformatf(
          "mismatch: exp mb=%0d idx=%0d data=%02h last=%0b, got mb=%0d idx=%0d data=%02h last=%0b",
          want.mailbox, want.pos, want.data, want.last,
          got.mailbox, got.pos, got.data, got.last));
    end
  endtask

  // request monitor, predictor and result checker
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        in_taken = 1'b1;
        n_requests++;
        decode_rx(in_if.rx_byte);
      end
      if (out_if.valid && out_if.ready) check_result();
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (rx_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.rx_byte <= rx_pending.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_sizes(input logic [39:0] v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.size_word <= v;
    do @(posedge clk); while (!cfg_if.ready);
    sizes_reg = v;
    n_settings++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_if.valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic push_frame(input logic [2:0] mb, input logic [3:0] len_m1, input int fill,
                            input frame_fault_e fault);
    int pkts;
    int n;
    logic [7:0] d;
    logic [7:0] ck;
    pkts = ((int'(len_m1) + 1) * 8 + 6) / 7;
    rx_pending.push_back(HDR_BIT | {1'b0, mb, len_m1});
    if (pkts > MAX_PACKETS) return;
    ck = '0;
    n = (fault == FR_ABORT) ? $urandom_range(pkts - 1) : pkts;
    for (int i = 0; i < n; i++) begin
      d = (fill < 0) ? 8'($urandom_range(127)) : 8'(fill);
      ck = ck ^ d;
      rx_pending.push_back(d);
    end
    case (fault)
      FR_ABORT:    rx_pending.push_back(HDR_BIT | 8'($urandom_range(127)));
      FR_CK_HIGH:  rx_pending.push_back(ck | HDR_BIT);
      FR_CK_WRONG: rx_pending.push_back((ck ^ 8'($urandom_range(1, 127))) & PKT_MASK);
      default:     rx_pending.push_back(ck);
    endcase
  endtask

  task automatic fill_random(input int count);
    int r;
    logic [3:0] len_m1;
    frame_fault_e fault;
    while (rx_pending.size() < count) begin
      r = $urandom_range(99);
      len_m1 = ($urandom_range(99) < 75) ? 4'($urandom_range(5)) : 4'($urandom_range(6, 13));
      if (r < 70) begin
        push_frame(3'($urandom_range(7)), len_m1, -1, FR_GOOD);
      end else if (r < 80) begin
        case ($urandom_range(2))
          0:       fault = FR_ABORT;
          1:       fault = FR_CK_HIGH;
          default: fault = FR_CK_WRONG;
        endcase
        push_frame(3'($urandom_range(7)), len_m1, -1, fault);
      end else if (r < 88) begin
        push_frame(3'($urandom_range(7)), 4'($urandom_range(14, 15)), -1, FR_GOOD);
        repeat ($urandom_range(3)) rx_pending.push_back(8'($urandom_range(127)));
      end else begin
        rx_pending.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  function automatic logic [39:0] rand_sizes();
    logic [39:0] v;
    for (int k = 0; k < 8; k++) v[5*k +: 5] = 5'($urandom_range(31));
    return v;
  endfunction

  task automatic run_phase(input int idle, input int stall, input logic [39:0] sizes);
    write_sizes(sizes);
    idle_pct = idle;
    stall_pct = stall;
    fill_random(ITEMS_PER_PHASE);
    wait_drained();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.size_word = '0;
    idle_pct = 0;
    stall_pct = 0;
    in_taken = 1'b0;
    errors = 0;
    cycles = 0;
    n_requests = 0;
    n_bursts = 0;
    n_checked = 0;
    n_settings = 0;
    sizes_reg = '0;
    rx_phase = PH_WAIT;
    rx_mailbox = '0;
    pkts_needed = '0;
    pkts_seen = '0;
    rx_xor = '0;
    for (int i = 0; i < MAX_BYTES; i++) msg_buf[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all sizes zero: a good frame delivers nothing
    write_sizes('0);
    push_frame(3'd5, 4'd0, -1, FR_GOOD);
    wait_drained();

    write_sizes({5'd3, 5'd8, 5'd17, 5'd5, 5'd1, 5'd0, 5'd31, 5'd16});
    rx_pending.push_back(8'h55);
    rx_pending.push_back(HDR_BIT | LEN_MASK);
    push_frame(3'd3, 4'd0, 127, FR_GOOD);
    push_frame(3'd1, 4'd1, 0, FR_GOOD);
    push_frame(3'd4, 4'd1, -1, FR_ABORT);
    push_frame(3'd6, 4'd0, -1, FR_CK_HIGH);
    push_frame(3'd7, 4'd0, -1, FR_CK_WRONG);
    push_frame(3'd2, 4'd0, -1, FR_GOOD);
    wait_drained();

    run_phase(0, 0, 40'hFF_FFFF_FFFF);
    run_phase(67, 0, rand_sizes());
    run_phase(0, 67, {8{5'd16}});
    run_phase(34, 34, rand_sizes());

    $display("%0d serial byte requests under %0d size settings, %0d bursts, %0d bytes checked",
             n_requests, n_settings, n_bursts, n_checked);
    $display("%0d errors", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
